// ===== design/sfsm_pkg.sv =====
`default_nettype none

package sfsm_pkg;

    // fixed field widths
    localparam int DATA_W    = 16;
    localparam int TERM_W    = 17;
    localparam int IDX_W     = 3;
    localparam int COL_W     = 3;
    localparam int TERMS     = 6;
    localparam int ROW_WORDS = TERMS + 1;
    localparam logic [COL_W-1:0] TRIM_COL = COL_W'(TERMS);
    localparam logic [COL_W-1:0] LAST_GAIN_COL = COL_W'(TERMS - 1);

    // accumulator covers six 16x17 products plus trim and stepped offset
    // at up to 15 gain fraction bits
    localparam int ACC_W = 38;

    localparam logic [16:0] TICK_MAX = 17'h1ffff;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef term_t [TERMS-1:0] terms_t;

    // tag that travels with each table read through the pipeline
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [IDX_W-1:0] servo;
        logic             first;
        logic             fin;
        logic             last;
    } tag_t;

endpackage

`default_nettype wire

// ===== design/state_feedback_servo_mixer.sv =====
`default_nettype none

// Linear state-feedback servo mixer. A word on the slave stream with tuser
// high is a sample: the step state is updated in the accept cycle, then each
// of the first servo_count servos (at most MAX_SERVOS) gets one command on
// the master stream, in servo order, tlast on the final one. The gain table
// sits in one memory with a single read port and is read one word per cycle
// (held while a finished command waits on a full output) through a shared
// multiply-accumulate pipeline, seven words per servo. A word with tuser low
// loads one table word (gain, or trim at column six) and gives no result.
// Table words read before being loaded are undefined.
// Registers lie on the APB port at byte address 4*i, in the order
// servo_count, step_period, step_amount, step_limit, step_mask,
// balance_pitch, balance_roll, balance_yaw; write them only while idle.
module state_feedback_servo_mixer #(
    parameter int MAX_SERVOS     = 5,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // sample or load word
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // table_row [2:0], table_col [5:3], table_value [21:6], pitch [37:22],
    // yaw [53:38], roll [69:54], rate_x [85:70], rate_y [101:86],
    // rate_z [117:102], zero [119:118]
    input  wire logic [119:0] s_tdata,
    // mode [0]
    input  wire logic         s_tuser,
    // servo commands
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // servo_index [2:0], servo_command [18:3], saturated [19], zero [23:20]
    output      logic [23:0]  m_tdata,
    output      logic         m_tlast,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    localparam int DEPTH  = MAX_SERVOS * sfsm_pkg::ROW_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] REG_SERVO_COUNT = 3'd0;
    localparam logic [2:0] REG_STEP_PERIOD = 3'd1;
    localparam logic [2:0] REG_STEP_AMOUNT = 3'd2;
    localparam logic [2:0] REG_STEP_LIMIT  = 3'd3;
    localparam logic [2:0] REG_STEP_MASK   = 3'd4;
    localparam logic [2:0] REG_BAL_PITCH   = 3'd5;
    localparam logic [2:0] REG_BAL_ROLL    = 3'd6;
    localparam logic [2:0] REG_BAL_YAW     = 3'd7;

    // configuration registers
    logic [2:0]  servo_count_reg;
    logic [15:0] step_period_reg;
    logic [14:0] step_amount_reg;
    logic [3:0]  step_limit_reg;
    logic [4:0]  step_mask_reg;
    logic [15:0] bal_pitch_reg;
    logic [15:0] bal_roll_reg;
    logic [15:0] bal_yaw_reg;

    // step state
    logic [16:0] tick_reg, tick_next;
    logic signed [15:0] step_offset_reg, step_offset_next;
    logic [3:0]  step_count_reg, step_count_next;

    // sequencer
    logic        busy_reg;
    logic [2:0]  servo_reg;
    logic [2:0]  col_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [3:0]  n_reg, n_next;

    sfsm_pkg::terms_t terms_reg;

    logic        cfg_wr;
    logic [2:0]  reg_sel;
    logic        accept, sample_acc, load_acc;
    logic        mac_busy, advance;
    logic        last_servo;
    logic [16:0] tick_inc;
    logic signed [16:0] step_diff;
    logic        step_hit;
    logic [5:0]  load_addr;
    logic        load_ok;
    logic        load_we;
    logic [ADDR_W-1:0] raddr;
    logic [15:0] ram_rdata;
    sfsm_pkg::tag_t tag0;

    logic [2:0]  in_row, in_col;
    logic [15:0] in_value;
    logic [15:0] in_pitch, in_yaw, in_roll, in_rx, in_ry, in_rz;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[21:6];
    assign in_pitch = s_tdata[37:22];
    assign in_yaw   = s_tdata[53:38];
    assign in_roll  = s_tdata[69:54];
    assign in_rx    = s_tdata[85:70];
    assign in_ry    = s_tdata[101:86];
    assign in_rz    = s_tdata[117:102];

    // apb register file
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg <= 3'd5;
            step_period_reg <= 16'd2000;
            step_amount_reg <= 15'd512;
            step_limit_reg  <= 4'd8;
            step_mask_reg   <= 5'd18;
            bal_pitch_reg   <= '0;
            bal_roll_reg    <= '0;
            bal_yaw_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SERVO_COUNT: servo_count_reg <= pwdata[2:0];
                REG_STEP_PERIOD: step_period_reg <= pwdata[15:0];
                REG_STEP_AMOUNT: step_amount_reg <= pwdata[14:0];
                REG_STEP_LIMIT:  step_limit_reg  <= pwdata[3:0];
                REG_STEP_MASK:   step_mask_reg   <= pwdata[4:0];
                REG_BAL_PITCH:   bal_pitch_reg   <= pwdata[15:0];
                REG_BAL_ROLL:    bal_roll_reg    <= pwdata[15:0];
                REG_BAL_YAW:     bal_yaw_reg     <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SERVO_COUNT: prdata = {29'd0, servo_count_reg};
            REG_STEP_PERIOD: prdata = {16'd0, step_period_reg};
            REG_STEP_AMOUNT: prdata = {17'd0, step_amount_reg};
            REG_STEP_LIMIT:  prdata = {28'd0, step_limit_reg};
            REG_STEP_MASK:   prdata = {27'd0, step_mask_reg};
            REG_BAL_PITCH:   prdata = {16'd0, bal_pitch_reg};
            REG_BAL_ROLL:    prdata = {16'd0, bal_roll_reg};
            REG_BAL_YAW:     prdata = {16'd0, bal_yaw_reg};
        endcase
    end

    // input handshake: one word at a time, pipeline drained
    assign s_tready   = !busy_reg && !mac_busy;
    assign accept     = s_tvalid && s_tready;
    assign sample_acc = accept && s_tuser;
    assign load_acc   = accept && !s_tuser;

    // table load address row*7+col
    assign load_addr = ({in_row, 3'b000} - {3'b000, in_row}) + {3'b000, in_col};
    assign load_ok   = ({1'b0, in_row} < 4'(MAX_SERVOS)) &&
                       ({1'b0, in_col} < 4'(sfsm_pkg::ROW_WORDS));
    assign load_we   = load_acc && load_ok;

    // tick counter and stepped offset
    assign tick_inc  = (tick_reg < sfsm_pkg::TICK_MAX) ? tick_reg + 17'd1 : tick_reg;
    assign step_hit  = (step_count_reg < step_limit_reg) && (tick_inc > {1'b0, step_period_reg});
    assign step_diff = {step_offset_reg[15], step_offset_reg} - {2'b00, step_amount_reg};

    always_comb
    begin
        tick_next        = tick_inc;
        step_offset_next = step_offset_reg;
        step_count_next  = step_count_reg;
        if (step_hit)
        begin
            tick_next       = '0;
            step_count_next = step_count_reg + 4'd1;
            if (step_diff[16] && !step_diff[15])
            begin
                step_offset_next = 16'sh8000;
            end
            else
            begin
                step_offset_next = step_diff[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            step_offset_reg <= '0;
            step_count_reg  <= '0;
        end
        else if (sample_acc)
        begin
            tick_reg        <= tick_next;
            step_offset_reg <= step_offset_next;
            step_count_reg  <= step_count_next;
        end
    end

    // state vector with balance angles removed
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            terms_reg[0] <= {in_pitch[15], in_pitch} - {bal_pitch_reg[15], bal_pitch_reg};
            terms_reg[1] <= {in_roll[15], in_roll} - {bal_roll_reg[15], bal_roll_reg};
            terms_reg[2] <= {in_yaw[15], in_yaw} - {bal_yaw_reg[15], bal_yaw_reg};
            terms_reg[3] <= {in_rx[15], in_rx};
            terms_reg[4] <= {in_ry[15], in_ry};
            terms_reg[5] <= {in_rz[15], in_rz};
        end
    end

    // servo count clamped to the table size
    assign n_next = ({1'b0, servo_count_reg} > 4'(MAX_SERVOS)) ? 4'(MAX_SERVOS)
                                                               : {1'b0, servo_count_reg};
    assign last_servo = ({1'b0, servo_reg} + 4'd1) == n_reg;

    // read sequencer: seven table words per servo
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            servo_reg <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            n_reg     <= '0;
        end
        else if (sample_acc)
        begin
            busy_reg  <= (n_next != 4'd0);
            servo_reg <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            n_reg     <= n_next;
        end
        else if (busy_reg && advance)
        begin
            if (col_reg == sfsm_pkg::TRIM_COL)
            begin
                col_reg   <= '0;
                servo_reg <= servo_reg + 3'd1;
                base_reg  <= base_reg + ADDR_W'(sfsm_pkg::ROW_WORDS);
                if (last_servo)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    assign raddr = base_reg + ADDR_W'(col_reg);

    always_comb
    begin
        tag0.valid = busy_reg;
        tag0.col   = col_reg;
        tag0.servo = servo_reg;
        tag0.first = (col_reg == 3'd0);
        tag0.fin   = (col_reg == sfsm_pkg::TRIM_COL);
        tag0.last  = last_servo;
    end

    // gain and trim table
    sfsm_ram #(
        .WIDTH (sfsm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr[ADDR_W-1:0]),
        .wdata (in_value),
        .re    (advance),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // multiply-accumulate, rounding and output word
    sfsm_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag_in      (tag0),
        .ram_rdata   (ram_rdata),
        .terms       (terms_reg),
        .step_offset (step_offset_reg),
        .step_mask   (step_mask_reg),
        .advance     (advance),
        .busy        (mac_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/sfsm_ram.sv =====
`default_nettype none

module sfsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 35
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sfsm_mac.sv =====
`default_nettype none

module sfsm_mac #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sfsm_pkg::tag_t                      tag_in,
    input  wire logic [sfsm_pkg::DATA_W-1:0]         ram_rdata,
    input  wire sfsm_pkg::terms_t                    terms,
    input  wire logic signed [sfsm_pkg::DATA_W-1:0]  step_offset,
    input  wire logic [4:0]                          step_mask,
    output      logic                                advance,
    output      logic                                busy,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // servo_index [2:0], servo_command [18:3], saturated [19], zero [23:20]
    output      logic [23:0]                         m_tdata,
    output      logic                                m_tlast
);

    localparam int AW = sfsm_pkg::ACC_W;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (GAIN_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] CMD_MAX = AW'(32767);
    localparam logic signed [AW-1:0] CMD_MIN = -AW'(32768);

    sfsm_pkg::tag_t t1_reg, t2_reg, t3_reg;
    logic signed [AW-1:0] p2_reg, p2_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic out_valid_reg;
    logic [sfsm_pkg::IDX_W-1:0] out_idx_reg;
    logic [sfsm_pkg::DATA_W-1:0] out_cmd_reg;
    logic out_sat_reg;
    logic out_last_reg;

    logic signed [sfsm_pkg::TERM_W-1:0] term_sel;
    logic signed [sfsm_pkg::DATA_W+sfsm_pkg::TERM_W-1:0] prod;
    logic signed [AW-1:0] trim_ext, step_ext;
    logic [7:0] mask_vec;
    logic signed [AW-1:0] rnd, shifted;
    logic sat_hi, sat_lo;
    logic [sfsm_pkg::DATA_W-1:0] cmd;
    logic emit;

    // whole pipeline holds while a finished command waits on a full output
    assign emit    = t3_reg.valid && t3_reg.fin;
    assign advance = !(emit && out_valid_reg && !m_tready);
    assign busy    = t1_reg.valid || t2_reg.valid || t3_reg.valid;

    // stage 1: table word against its state term, or trim plus stepped offset
    always_comb
    begin
        unique case (t1_reg.col)
            3'd0:    term_sel = terms[0];
            3'd1:    term_sel = terms[1];
            3'd2:    term_sel = terms[2];
            3'd3:    term_sel = terms[3];
            3'd4:    term_sel = terms[4];
            3'd5:    term_sel = terms[5];
            default: term_sel = '0;
        endcase
    end

    assign mask_vec = {3'b000, step_mask};
    assign prod     = $signed(ram_rdata) * term_sel;
    assign trim_ext = AW'($signed(ram_rdata)) <<< GAIN_FRAC_BITS;
    assign step_ext = mask_vec[t1_reg.servo] ? (AW'(step_offset) <<< GAIN_FRAC_BITS) : '0;

    always_comb
    begin
        if (t1_reg.col == sfsm_pkg::TRIM_COL)
        begin
            p2_next = trim_ext + step_ext;
        end
        else
        begin
            p2_next = AW'(prod);
        end
    end

    // stage 2: accumulate over the row
    assign acc_next = t2_reg.first ? p2_reg : acc_reg + p2_reg;

    // stage 3: round half up and saturate
    assign rnd     = acc_reg + ROUND_HALF;
    assign shifted = rnd >>> GAIN_FRAC_BITS;
    assign sat_hi  = shifted > CMD_MAX;
    assign sat_lo  = shifted < CMD_MIN;

    always_comb
    begin
        priority if (sat_hi)
        begin
            cmd = 16'h7fff;
        end
        else if (sat_lo)
        begin
            cmd = 16'h8000;
        end
        else
        begin
            cmd = shifted[sfsm_pkg::DATA_W-1:0];
        end
    end

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else if (advance)
        begin
            t1_reg <= tag_in;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p2_reg <= p2_next;
            if (t2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && advance)
        begin
            out_idx_reg  <= t3_reg.servo;
            out_cmd_reg  <= cmd;
            out_sat_reg  <= sat_hi || sat_lo;
            out_last_reg <= t3_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_sat_reg, out_cmd_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
